FILE: hw/rtl/aarc_pkg.sv
// Shared widths, register indexes and constants of the rounded-corner coverage block.
package aarc_pkg;

	localparam int PIX_W  = 6;   // pixel coordinate width
	localparam int RAD_W  = 7;   // radius and border register width
	localparam int PCT_W  = 7;   // percentage width
	localparam int CIDX_W = 2;   // configuration index width

	localparam logic [CIDX_W-1:0] REG_RADIUS = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] REG_BORDER = CIDX_W'(1);

	localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(8);
	localparam logic [RAD_W-1:0] BORDER_RST = RAD_W'(0);

	localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

endpackage

FILE: hw/rtl/aarc_sqrt_pipe.sv
// Pipelined digit-by-digit square root of (sum << (2*FRAC_BITS-2)), one root bit per stage.
module aarc_sqrt_pipe import aarc_pkg::*; #(
	parameter int SUM_W     = 15,
	parameter int FRAC_BITS = 8,
	parameter int ROOT_W    = (SUM_W + 1) / 2 + FRAC_BITS - 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SUM_W-1:0]  sum,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 2;
	localparam int RAD_W2 = 2 * ROOT_W;

	logic              vld_s  [ROOT_W];
	logic              rdy    [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SUM_W-1:0]  sum_s  [ROOT_W-1];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int J = ROOT_W - 1 - k;

		logic              vld_in;
		logic              rdy_next;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SUM_W-1:0]  sum_in;
		logic [RAD_W2-1:0] rad;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign sum_in  = sum;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign sum_in  = sum_s[k-1];
		end

		if (k == ROOT_W - 1) begin : g_last
			assign rdy_next = out_ready;
		end else begin : g_mid
			assign rdy_next = rdy[k+1];
		end

		assign rdy[k] = !vld_s[k] || rdy_next;

		// next pair of radicand bits, low bits of the radicand are zero
		assign rad    = RAD_W2'(sum_in) << (2 * FRAC_BITS - 2);
		assign rem_sh = {rem_in[ROOT_W-1:0], rad[2*J+1:2*J]};
		assign trial  = {root_in, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld_in) begin
				rem_s[k]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
			end
		end

		if (k < ROOT_W - 1) begin : g_sum
			always_ff @(posedge clk) begin
				if (rdy[k] && vld_in) begin
					sum_s[k] <= sum_in;
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];

endmodule

FILE: hw/rtl/aa_round_corner_coverage.sv
// Top level: anti-aliased coverage for one corner box of a rounded rectangle.
// One pixel item is taken and one result item leaves per clock while out_ready is high.
// Three front stages mirror the pixel, square and add; the square root then resolves one
// bit per register stage; two back stages form the clamped coverage and the rounded
// percentages. Valid travels with each item and ready is chained stage by stage, so
// bubbles close up under a stalled output. radius and border_width are written through
// the configuration port (always ready) and must only change while no item is in flight.
module aa_round_corner_coverage import aarc_pkg::*; #(
	parameter int MAX_RADIUS = 64,
	parameter int FRAC_BITS  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [RAD_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PIX_W-1:0]  pixel_x,
	input  logic [PIX_W-1:0]  pixel_y,
	input  logic              mirror_x,
	input  logic              mirror_y,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PCT_W-1:0]  outer_percent,
	output logic [PCT_W-1:0]  inner_percent,
	output logic              fully_inside
);

	localparam int RCAP   = (MAX_RADIUS > 127) ? 127 : MAX_RADIUS;
	localparam int DW     = $clog2(2 * RCAP);
	localparam int AW     = DW - 1;
	localparam int SQW    = 2 * DW;
	localparam int SW     = SQW + 1;
	localparam int ROOT_W = (SW + 1) / 2 + FRAC_BITS - 1;
	localparam int CW0    = RAD_W + FRAC_BITS + 1;
	localparam int CW     = ((CW0 > ROOT_W) ? CW0 : ROOT_W) + 1;
	localparam int PMW    = FRAC_BITS + 1 + PCT_W;
	localparam logic [CW-1:0] HALF_C = CW'(1) << (FRAC_BITS - 1);
	localparam logic [CW-1:0] ONE_C  = CW'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;
	localparam logic [PMW-1:0] HALF_P = PMW'(1) << (FRAC_BITS - 1);

	// ---------------- configuration ----------------
	logic [RAD_W-1:0] radius_q;
	logic [RAD_W-1:0] border_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			border_q <= BORDER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data;
				REG_BORDER: border_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [RAD_W-1:0] r_one;
	logic [RAD_W-1:0] r_eff;
	logic [RAD_W-1:0] r_m1;
	logic [RAD_W-1:0] bw_c;
	logic [RAD_W-1:0] ra_in;

	always_comb begin
		r_one = (radius_q == '0) ? RAD_W'(1) : radius_q;
		r_eff = (r_one > RAD_W'(RCAP)) ? RAD_W'(RCAP) : r_one;
		r_m1  = r_eff - RAD_W'(1);
		bw_c  = (border_q > r_eff) ? r_eff : border_q;
		ra_in = r_eff - bw_c;
	end

	// ---------------- stage 1: clamp, mirror, doubled offset ----------------
	logic          v_s1, v_s2, v_s3;
	logic          rdy1, rdy2, rdy3;
	logic          sq_in_ready;
	logic [DW-1:0] dx_s1, dy_s1;

	function automatic logic [AW-1:0] offset_f(input logic [PIX_W-1:0] p, input logic m,
		input logic [RAD_W-1:0] rm1);
		logic [RAD_W-1:0] pc;
		logic [RAD_W-1:0] a;
		pc = (RAD_W'(p) > rm1) ? rm1 : RAD_W'(p);
		a  = m ? pc : (rm1 - pc);
		return a[AW-1:0];
	endfunction

	assign rdy3     = !v_s3 || sq_in_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// dx = 2*(r - mx) - 1, odd by construction
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			dx_s1 <= {offset_f(pixel_x, mirror_x, r_m1), 1'b1};
			dy_s1 <= {offset_f(pixel_y, mirror_y, r_m1), 1'b1};
		end
	end

	// ---------------- stage 2: squares ----------------
	logic [SQW-1:0] dx2_s2, dy2_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			dx2_s2 <= SQW'(dx_s1) * SQW'(dx_s1);
			dy2_s2 <= SQW'(dy_s1) * SQW'(dy_s1);
		end
	end

	// ---------------- stage 3: sum of squares ----------------
	logic [SW-1:0] sum_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			sum_s3 <= SW'(dx2_s2) + SW'(dy2_s2);
		end
	end

	// ---------------- square root ----------------
	logic              sq_valid;
	logic              sq_ready;
	logic [ROOT_W-1:0] dq;

	aarc_sqrt_pipe #(
		.SUM_W     (SW),
		.FRAC_BITS (FRAC_BITS),
		.ROOT_W    (ROOT_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (sq_in_ready),
		.sum       (sum_s3),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.root      (dq)
	);

	// ---------------- stage 4: coverage ----------------
	logic               v_s4, v_s5;
	logic               rdy4, rdy5;
	logic [FRAC_BITS:0] co_s4, ci_s4;

	function automatic logic [FRAC_BITS:0] cov_f(input logic [RAD_W-1:0] ra,
		input logic [ROOT_W-1:0] d);
		logic [CW-1:0] a;
		logic [CW-1:0] b;
		logic [CW-1:0] c;
		a = (CW'(ra) << FRAC_BITS) + HALF_C;
		b = CW'(d);
		c = a - b;
		if (b >= a) begin
			return '0;
		end else if (c > ONE_C) begin
			return ONE_Q;
		end
		return c[FRAC_BITS:0];
	endfunction

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign sq_ready = rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy4) begin
				v_s4 <= sq_valid;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && sq_valid) begin
			co_s4 <= cov_f(r_eff, dq);
			ci_s4 <= cov_f(ra_in, dq);
		end
	end

	// ---------------- stage 5: rounded percentages ----------------
	logic [PCT_W-1:0] outer_s5, inner_s5;
	logic             full_s5;

	function automatic logic [PCT_W-1:0] pct_f(input logic [FRAC_BITS:0] cq);
		logic [PMW-1:0] p;
		p = PMW'(cq) * PMW'(PCT_FULL) + HALF_P;
		return PCT_W'(p >> FRAC_BITS);
	endfunction

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			outer_s5 <= pct_f(co_s4);
			inner_s5 <= pct_f(ci_s4);
			full_s5  <= (co_s4 == ONE_Q);
		end
	end

	assign out_valid     = v_s5;
	assign outer_percent = outer_s5;
	assign inner_percent = inner_s5;
	assign fully_inside  = full_s5;

	// ---------------- checks ----------------
	a_full_is_hundred: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fully_inside |-> outer_percent == PCT_FULL)
		else $error("fully_inside without full outer coverage");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outer_percent <= PCT_FULL && inner_percent <= PCT_FULL)
		else $error("percentage above full");

	a_inner_le_outer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inner_percent <= outer_percent)
		else $error("fill coverage exceeds outer coverage");

	a_stall_front: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3)
		else $error("input held off with a bubble in the front stages");

endmodule

FILE: bench/tb_aa_round_corner_coverage.sv
// Self-checking bench for the rounded-corner coverage block: directed corners, then random phases.
`timescale 1ns / 1ps

module tb_aa_round_corner_coverage import aarc_pkg::*;;

	localparam int MAX_RAD      = 64;
	localparam int FRAC         = 8;
	localparam int LATENCY      = 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 38;

	// no register sits at this index; writes to it must change nothing
	localparam logic [CIDX_W-1:0] REG_SPARE = CIDX_W'(3);

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// Expected coverage per accepted pixel, worked out from the current corner geometry.
	class coverage_ledger;
		localparam int ONE  = 1 << FRAC;
		localparam int HALF = 1 << (FRAC - 1);

		typedef struct packed {
			logic [PCT_W-1:0] outer;
			logic [PCT_W-1:0] inner;
			logic             full;
		} corner_cov_t;

		corner_cov_t       cov_due[$];
		logic [RAD_W-1:0]  rad;
		logic [RAD_W-1:0]  border;
		int unsigned       errors;
		int unsigned       seen;

		function new();
			rad    = RADIUS_RST;
			border = BORDER_RST;
			errors = 0;
			seen   = 0;
		endfunction

		function void set_reg(logic [CIDX_W-1:0] idx, logic [RAD_W-1:0] data);
			case (idx)
				REG_RADIUS: rad = data;
				REG_BORDER: border = data;
				default: ;
			endcase
		endfunction

		function int unsigned box_side();
			if (rad == 0)
				return 1;
			if (rad > MAX_RAD)
				return MAX_RAD;
			return rad;
		endfunction

		function int pending();
			return cov_due.size();
		endfunction

		// largest s with s*s <= v, one bit at a time from the top
		function longint unsigned root_floor(longint unsigned v);
			longint unsigned s, trial;
			s = 0;
			for (int b = 15; b >= 0; b--) begin
				trial = s | (64'd1 << b);
				if (trial * trial <= v)
					s = trial;
			end
			return s;
		endfunction

		function int unsigned arc_cover(longint unsigned dq, int unsigned ra);
			longint c;
			c = (longint'(ra) << FRAC) + HALF - longint'(dq);
			if (c < 0)
				return 0;
			if (c > ONE)
				return ONE;
			return int'(c);
		endfunction

		function logic [PCT_W-1:0] to_pct(int unsigned c);
			return PCT_W'((100 * c + HALF) >> FRAC);
		endfunction

		function void take_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
					 logic fx, logic fy);
			int unsigned      r, bw, cx, cy, ox, oy, ex, ey, c_out, c_in;
			longint unsigned  sq, dq;
			corner_cov_t      want;
			r  = box_side();
			bw = border;
			if (bw > r)
				bw = r;
			// pixels beyond the box sit on its last row or column
			cx = (px > r - 1) ? r - 1 : px;
			cy = (py > r - 1) ? r - 1 : py;
			ox = fx ? r - 1 - cx : cx;
			oy = fy ? r - 1 - cy : cy;
			ex = 2 * (r - ox) - 1;
			ey = 2 * (r - oy) - 1;
			sq = longint'(ex) * ex + longint'(ey) * ey;
			dq    = root_floor(sq << (2 * FRAC - 2));
			c_out = arc_cover(dq, r);
			c_in  = (bw == 0) ? c_out : arc_cover(dq, r - bw);
			want.outer = to_pct(c_out);
			want.inner = to_pct(c_in);
			want.full  = (c_out >= ONE);
			cov_due.push_back(want);
		endfunction

		task report(string msg);
			$display("mismatch at result %0d: %s", seen, msg);
			errors++;
		endtask

		task match_result(logic [PCT_W-1:0] outer, logic [PCT_W-1:0] inner, logic full);
			corner_cov_t want;
			if (cov_due.size() == 0) begin
				report($sformatf("unexpected result outer=%0d inner=%0d full=%0d",
						 outer, inner, full));
				seen++;
				return;
			end
			want = cov_due.pop_front();
			if (outer !== want.outer)
				report($sformatf("outer_percent %0d, want %0d", outer, want.outer));
			if (inner !== want.inner)
				report($sformatf("inner_percent %0d, want %0d", inner, want.inner));
			if (full !== want.full)
				report($sformatf("fully_inside %0d, want %0d", full, want.full));
			seen++;
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index;
	logic [RAD_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [PIX_W-1:0]  pixel_x;
	logic [PIX_W-1:0]  pixel_y;
	logic              mirror_x;
	logic              mirror_y;
	logic              out_valid;
	logic              out_ready;
	logic [PCT_W-1:0]  outer_percent;
	logic [PCT_W-1:0]  inner_percent;
	logic              fully_inside;

	coverage_ledger ledger;
	int unsigned    send_idle_pct;
	int unsigned    recv_stall_pct;
	int unsigned    hold_asks;
	int unsigned    hold_served;
	int unsigned    cycle_count;

	aa_round_corner_coverage #(
		.MAX_RADIUS(MAX_RAD),
		.FRAC_BITS (FRAC)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.mirror_x     (mirror_x),
		.mirror_y     (mirror_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.outer_percent(outer_percent),
		.inner_percent(inner_percent),
		.fully_inside (fully_inside)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off whenever one is asked for.
	initial begin
		out_ready   = 1'b0;
		hold_served = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_asks != hold_served) begin
				out_ready <= 1'b0;
				hold_served = hold_asks;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.match_result(outer_percent, inner_percent, fully_inside);
	end

	function automatic void set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SEND: begin send_idle_pct = 69; recv_stall_pct = 0;  end
			IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 69; end
			IDLE_BOTH: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
			default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
		endcase
	endfunction

	task automatic write_cfg(logic [CIDX_W-1:0] idx, logic [RAD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		ledger.set_reg(idx, data);
	endtask

	// Block must be idle here; cfg_valid stays high across the writes of one call.
	task automatic set_corner(int unsigned r, int unsigned b, bit spare);
		if (spare)
			write_cfg(REG_SPARE, RAD_W'($urandom_range(127)));
		write_cfg(REG_RADIUS, RAD_W'(r));
		write_cfg(REG_BORDER, RAD_W'(b));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(int unsigned x, int unsigned y, bit fx, bit fy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x  <= PIX_W'(x);
		pixel_y  <= PIX_W'(y);
		mirror_x <= fx;
		mirror_y <= fy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ledger.take_pixel(PIX_W'(x), PIX_W'(y), fx, fy);
	endtask

	task automatic send_random();
		int unsigned side, x, y;
		side = ledger.box_side();
		// mostly inside the box, now and then anywhere in the field range
		x = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(side - 1);
		y = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(side - 1);
		send_pixel(x, y, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic drain();
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	// Call only at the edge where the last item was taken.
	task automatic finish_batch();
		in_valid <= 1'b0;
		drain();
	endtask

	initial begin
		int unsigned r, b;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_RADIUS;
		cfg_data    = '0;
		in_valid    = 1'b0;
		pixel_x     = '0;
		pixel_y     = '0;
		mirror_x    = 1'b0;
		mirror_y    = 1'b0;
		hold_asks   = 0;
		ledger      = new();
		set_idling(IDLE_NONE);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry, all four corners, a pixel beyond the box
		send_pixel(0, 0, 0, 0);
		send_pixel(7, 7, 0, 0);
		send_pixel(7, 7, 1, 1);
		send_pixel(0, 5, 1, 0);
		send_pixel(63, 63, 0, 1);
		send_pixel(2, 6, 0, 0);
		finish_batch();

		// zero radius acts as one; border eats the whole fill arc
		set_corner(0, 1, 0);
		send_pixel(0, 0, 0, 0);
		send_pixel(63, 42, 1, 1);
		finish_batch();

		// oversized radius saturates, border beyond it clamps
		set_corner(127, 100, 0);
		send_pixel(63, 63, 1, 1);
		send_pixel(0, 0, 0, 0);
		send_pixel(21, 42, 1, 0);
		finish_batch();

		set_corner(64, 64, 0);
		send_pixel(0, 63, 0, 1);
		send_pixel(63, 0, 1, 0);
		finish_batch();

		set_corner(1, 0, 0);
		send_pixel(0, 0, 1, 0);
		finish_batch();

		set_corner(20, 5, 1);
		send_pixel(19, 0, 0, 0);
		send_pixel(10, 10, 1, 1);
		send_pixel(0, 19, 0, 0);
		send_pixel(13, 7, 0, 1);
		finish_batch();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin r = 64;  b = 0;   end
				1: begin r = 1;   b = 1;   end
				2: begin r = 127; b = 127; end
				default: begin
					case ($urandom_range(7))
						0: r = 0;
						1: r = $urandom_range(65, 127);
						default: r = $urandom_range(1, 64);
					endcase
					case ($urandom_range(3))
						0: b = 0;
						1: b = $urandom_range(127);
						default: b = $urandom_range((r > 64) ? 64 : r);
					endcase
				end
			endcase
			set_corner(r, b, ph == 5);
			set_idling(idle_mode_t'(ph % 4));
			// fill the pipe against a held-off output
			if (ph == 4)
				hold_asks <= hold_asks + 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 6 && n == PHASE_ITEMS / 2)
					finish_batch();
				send_random();
			end
			finish_batch();
		end

		repeat (3 * LATENCY) @(posedge clk);
		if (ledger.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
